/* rtl/grid_dfs_tour_walker_core_assert.svh */
// Assertion macros used by the checker of the grid walker.
`ifndef GRID_DFS_TOUR_WALKER_CORE_ASSERT_SVH
`define GRID_DFS_TOUR_WALKER_CORE_ASSERT_SVH

// Checked at every rising edge of clk, ignored while rst is high.
`define GDTW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, reset cycles included.
`define GDTW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/gdtw_pkg.sv */
// Shared constants, codes and types of the grid walker.
`default_nettype none
package gdtw_pkg;

  localparam int MAX_SIDE = 64;
  localparam int COORD_W  = $clog2(MAX_SIDE);
  localparam int CELL_W   = 2 * COORD_W;
  localparam int CELLS    = MAX_SIDE * MAX_SIDE;
  localparam int SIDE_W   = 7;
  localparam int SP_W     = CELL_W + 1;
  localparam int EPOCH_W  = 4;
  localparam int NEXT_W   = 3;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_STEP    = 2'd2;

  localparam logic [1:0] REG_GRID_SIDE = 2'd0;
  localparam logic [1:0] REG_START_ROW = 2'd1;
  localparam logic [1:0] REG_START_COL = 2'd2;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [NEXT_W-1:0]  next;
    logic [1:0]         came;
  } frame_t;

  typedef struct packed {
    logic clr_step;
    logic clr_end;
    logic load;
    logic restart;
    logic next_dir;
    logic push;
    logic pop;
    logic pop_load;
    logic finish;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic epoch_full;
    logic finished;
    logic dirs_done;
    logic at_base;
    logic nbr_inb;
    logic nbr_blocked;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

/* rtl/gdtw_ctrl.sv */
// Controller state machine of the grid walker.
`default_nettype none
module gdtw_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  input  wire logic [1:0]            s_cmd,
  output logic                       s_tready,
  input  wire gdtw_pkg::dp_stat_t    stat,
  output gdtw_pkg::ctrl_cmd_t        cmd
);
  import gdtw_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_RESTART = 7'b0000100,
    S_PROBE   = 7'b0001000,
    S_EVAL    = 7'b0010000,
    S_POP     = 7'b0100000,
    S_EMIT    = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   pend, pend_next;
  logic   accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  always_comb begin
    state_next = state;
    pend_next  = pend;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          cmd.clr_end = 1'b1;
          pend_next   = 1'b0;
          state_next  = pend ? S_RESTART : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (s_cmd)
            CMD_LOAD: cmd.load = 1'b1;
            CMD_RESTART: begin
              // The visited epoch is about to wrap: sweep the map first.
              if (stat.epoch_full) begin
                pend_next  = 1'b1;
                state_next = S_CLEAR;
              end else begin
                state_next = S_RESTART;
              end
            end
            CMD_STEP: begin
              if (stat.finished) begin
                cmd.finish = 1'b1;
                state_next = S_EMIT;
              end else begin
                state_next = S_PROBE;
              end
            end
            default: ;
          endcase
        end
      end
      S_RESTART: begin
        cmd.restart = 1'b1;
        state_next  = S_IDLE;
      end
      S_PROBE: begin
        if (stat.dirs_done) begin
          if (stat.at_base) begin
            cmd.finish = 1'b1;
            state_next = S_EMIT;
          end else begin
            cmd.pop    = 1'b1;
            state_next = S_POP;
          end
        end else if (!stat.nbr_inb) begin
          cmd.next_dir = 1'b1;
        end else begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.nbr_blocked) begin
          cmd.next_dir = 1'b1;
          state_next   = S_PROBE;
        end else begin
          cmd.push   = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_POP: begin
        cmd.pop_load = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/gdtw_dp.sv */
// Datapath of the grid walker: maps, frame stack, top frame and result register.
`default_nettype none
module gdtw_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_addr,
  input  wire logic [gdtw_pkg::SIDE_W-1:0]   cfg_wdata,
  input  wire logic [gdtw_pkg::COORD_W-1:0]  cell_row,
  input  wire logic [gdtw_pkg::COORD_W-1:0]  cell_col,
  input  wire logic                          cell_blocked,
  input  wire gdtw_pkg::ctrl_cmd_t           cmd,
  output gdtw_pkg::dp_stat_t                 stat,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [1:0]                         move_dir,
  output logic                               tour_done
);
  import gdtw_pkg::*;

  logic [SIDE_W-1:0]  grid_side;
  logic [COORD_W-1:0] start_row;
  logic [COORD_W-1:0] start_col;
  logic [SIDE_W-1:0]  eff_side;

  logic               wall_mem [CELLS];
  logic [EPOCH_W-1:0] vis_mem  [CELLS];
  frame_t             stk_mem  [CELLS];

  logic               wall_q;
  logic [EPOCH_W-1:0] vis_q;
  frame_t             stk_q;

  frame_t             cur;
  logic [SP_W-1:0]    sp;
  logic               finished;
  logic [EPOCH_W-1:0] epoch;
  logic [CELL_W-1:0]  clr_cnt;
  logic [1:0]         res_dir;
  logic               res_done;

  logic [SIDE_W-1:0]  nr, nc;
  logic [CELL_W-1:0]  nbr_idx;
  logic               vis_we;
  logic [CELL_W-1:0]  vis_waddr;
  logic [EPOCH_W-1:0] vis_wdata;
  logic [SP_W-1:0]    sp_wr, sp_rd;
  frame_t             push_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= SIDE_W'(MAX_SIDE);
      start_row <= '0;
      start_col <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GRID_SIDE: grid_side <= cfg_wdata;
        REG_START_ROW: start_row <= cfg_wdata[COORD_W-1:0];
        REG_START_COL: start_col <= cfg_wdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_side = (grid_side > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : grid_side;

  // Neighbor of the top frame in the direction under test. A step up or left
  // from the edge wraps to a large value, which fails the bound check.
  always_comb begin
    nr = {1'b0, cur.row};
    nc = {1'b0, cur.col};
    case (cur.next[1:0])
      DIR_UP:    nr = nr - SIDE_W'(1);
      DIR_DOWN:  nr = nr + SIDE_W'(1);
      DIR_LEFT:  nc = nc - SIDE_W'(1);
      DIR_RIGHT: nc = nc + SIDE_W'(1);
      default: ;
    endcase
  end

  assign nbr_idx = {nr[COORD_W-1:0], nc[COORD_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wall_mem[{cell_row, cell_col}] <= cell_blocked;
    end
    wall_q <= wall_mem[nbr_idx];
  end

  // A cell counts as visited when its entry equals the current epoch.
  always_comb begin
    vis_we    = cmd.clr_step || cmd.restart || cmd.push;
    vis_waddr = nbr_idx;
    vis_wdata = epoch;
    if (cmd.clr_step) begin
      vis_waddr = clr_cnt;
      vis_wdata = '0;
    end else if (cmd.restart) begin
      vis_waddr = {start_row, start_col};
      vis_wdata = epoch + EPOCH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    vis_q <= vis_mem[nbr_idx];
  end

  // The top frame lives in registers; the memory holds the frames below it.
  assign sp_wr = sp - SP_W'(1);
  assign sp_rd = sp - SP_W'(2);

  always_comb begin
    push_frame      = cur;
    push_frame.next = cur.next + NEXT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk_mem[sp_wr[CELL_W-1:0]] <= push_frame;
    end
    stk_q <= stk_mem[sp_rd[CELL_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.restart) begin
      cur.row  <= start_row;
      cur.col  <= start_col;
      cur.next <= '0;
      cur.came <= DIR_UP;
    end else if (cmd.push) begin
      cur.row  <= nr[COORD_W-1:0];
      cur.col  <= nc[COORD_W-1:0];
      cur.next <= '0;
      cur.came <= cur.next[1:0];
    end else if (cmd.pop_load) begin
      cur <= stk_q;
    end else if (cmd.next_dir) begin
      cur.next <= cur.next + NEXT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp       <= '0;
      finished <= 1'b1;
      epoch    <= '0;
      clr_cnt  <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + CELL_W'(1);
      end
      if (cmd.clr_end) begin
        epoch <= '0;
      end else if (cmd.restart) begin
        epoch <= epoch + EPOCH_W'(1);
      end
      if (cmd.restart) begin
        sp       <= SP_W'(1);
        finished <= 1'b0;
      end else if (cmd.finish) begin
        sp       <= '0;
        finished <= 1'b1;
      end else if (cmd.push) begin
        sp <= sp + SP_W'(1);
      end else if (cmd.pop) begin
        sp <= sp_wr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_dir  <= DIR_UP;
      res_done <= 1'b1;
    end else if (cmd.push) begin
      res_dir  <= cur.next[1:0];
      res_done <= 1'b0;
    end else if (cmd.pop) begin
      res_dir  <= cur.came ^ 2'b01;
      res_done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      move_dir  <= res_dir;
      tour_done <= res_done;
    end
  end

  always_comb begin
    stat.clr_last    = &clr_cnt;
    stat.epoch_full  = &epoch;
    stat.finished    = finished;
    stat.dirs_done   = cur.next[NEXT_W-1];
    stat.at_base     = (sp == SP_W'(1));
    stat.nbr_inb     = (nr < eff_side) && (nc < eff_side);
    stat.nbr_blocked = wall_q || (vis_q == epoch);
    stat.out_free    = !m_tvalid || m_tready;
  end

endmodule
`default_nettype wire

/* rtl/grid_dfs_tour_walker_core.sv */
// Top level of the depth-first grid walker.
//
// Input beats (s_*): s_tuser holds the command: load one grid cell, restart
// the walk, or step. A load writes the wall bit of one cell, a restart puts
// the start cell on the frame stack, and neither returns a beat. Every step
// returns exactly one beat on m_*: the move taken, or tour_done once the
// walk is back at the start with nothing left to explore.
// Configuration (cfg_*): grid side, start row and start column, written by
// index while the block is idle; they act on the next restart or step.
// Sequence: a step on a finished walk goes straight to the result load. Each
// direction tried is checked against the grid side; one that lies in the
// grid also has its wall and visited bits read before it is judged. The
// last check is followed by the result load, and a retreat first reads the
// frame below from the stack memory. The 16th restart after reset and every
// 15th after it first sweep the visited map, since marks are kept per restart
// epoch.
// Reset: a sweep clears all 4096 visited map entries, with s_tready low; the
// walk is finished, so steps return tour_done until a restart.
// Stall: the result register holds the beat until m_tready; a later step is
// worked out, then keeps s_tready low until the held beat drains.
`default_nettype none
module grid_dfs_tour_walker_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [15:0]                  s_tdata,   // cell_row, cell_col, cell_blocked
  input  wire logic [1:0]                   s_tuser,   // cmd
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [7:0]                        m_tdata,   // move_dir
  output logic [0:0]                        m_tuser,   // tour_done
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_addr,
  input  wire logic [gdtw_pkg::SIDE_W-1:0]  cfg_wdata
);
  import gdtw_pkg::*;

  ctrl_cmd_t  cmd;
  dp_stat_t   stat;
  logic [1:0] move_dir;
  logic       tour_done;

  gdtw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_cmd    (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gdtw_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .cell_row     (s_tdata[COORD_W-1:0]),
    .cell_col     (s_tdata[2*COORD_W-1:COORD_W]),
    .cell_blocked (s_tdata[2*COORD_W]),
    .cmd          (cmd),
    .stat         (stat),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .move_dir     (move_dir),
    .tour_done    (tour_done)
  );

  assign m_tdata = {6'b0, move_dir};
  assign m_tuser = tour_done;

endmodule
`default_nettype wire

/* rtl/gdtw_checker.sv */
// Port-level checks of the grid walker, bound to its top level.
`default_nettype none
`include "grid_dfs_tour_walker_core_assert.svh"
module gdtw_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic [1:0]                   s_tuser,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [7:0]                   m_tdata,
  input wire logic [0:0]                   m_tuser
);
  import gdtw_pkg::*;

  logic s_beat;
  assign s_beat = s_tvalid && s_tready;

  // The result beat holds while the receiver stalls.
  `GDTW_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  // A finished walk reports no move.
  `GDTW_ASSERT(a_done_no_move, m_tvalid && m_tuser[0] |-> m_tdata == 8'd0, "done beat carries a move")
  // Loads, restarts and unused commands never produce a result beat.
  `GDTW_ASSERT(a_no_spurious, s_beat && s_tuser != CMD_STEP |=> !$rose(m_tvalid), "result beat without a step")
  // A step keeps the input side closed until its result is produced.
  `GDTW_ASSERT(a_step_busy, s_beat && s_tuser == CMD_STEP |=> !s_tready, "step accepted while busy")
  // Reset starts the visited map sweep with nothing on the output.
  `GDTW_ASSERT_ALWAYS(a_reset_sweep, rst |=> !s_tready && !m_tvalid, "block open right after reset")

endmodule

bind grid_dfs_tour_walker_core gdtw_checker u_gdtw_checker (.*);
`default_nettype wire

/* dv/grid_dfs_tour_walker_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench that walks random grids and compares every move beat.
module grid_dfs_tour_walker_core_tb;
  import gdtw_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int GRID_CELLS = MAX_SIDE * MAX_SIDE;
  localparam int ITEM_GOAL = 1300;

  typedef struct packed {
    logic [1:0] dir;
    logic       done;
  } move_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata = '0;   // cell_row, cell_col, cell_blocked
  logic [1:0]        s_tuser = CMD_LOAD;   // cmd
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;   // move_dir
  logic [0:0]        m_tuser;   // tour_done
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_addr = REG_GRID_SIDE;
  logic [SIDE_W-1:0] cfg_wdata = '0;

  // Predicted state of the walker.
  logic [SIDE_W-1:0]  side_cfg = 7'd64;
  logic [COORD_W-1:0] start_row_cfg = '0;
  logic [COORD_W-1:0] start_col_cfg = '0;
  bit                 wall_bit [GRID_CELLS];
  bit                 seen_bit [GRID_CELLS];
  int                 trail_row [GRID_CELLS + 1];
  int                 trail_col [GRID_CELLS + 1];
  int                 trail_next [GRID_CELLS + 1];
  logic [1:0]         trail_came [GRID_CELLS + 1];
  int                 trail_depth = 0;
  bit                 walk_over = 1'b1;
  move_t              moves_due [$];

  int err_cnt = 0;
  int items_sent = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int box_r0 = 0, box_c0 = 0, box_h = 0, box_w = 0;

  grid_dfs_tour_walker_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  task automatic note_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Appends one expected result beat.
  task automatic queue_move(logic [1:0] dir, logic done);
    move_t m;
    m.dir = dir;
    m.done = done;
    moves_due.insert(moves_due.size(), m);
  endtask

  // One step of the tour: advance into the next free neighbor, back out, or finish.
  task automatic predict_move();
    int side, top, nr, nc, cidx;
    logic [1:0] kd;
    bit found;
    side = (side_cfg > MAX_SIDE) ? MAX_SIDE : int'(side_cfg);
    if (walk_over || trail_depth == 0) begin
      walk_over = 1'b1;
      queue_move(DIR_UP, 1'b1);
      return;
    end
    top = trail_depth - 1;
    found = 1'b0;
    while (!found && trail_next[top] < 4) begin
      kd = trail_next[top][1:0];
      trail_next[top]++;
      nr = trail_row[top];
      nc = trail_col[top];
      case (kd)
        DIR_UP:   nr = nr - 1;
        DIR_DOWN: nr = nr + 1;
        DIR_LEFT: nc = nc - 1;
        default:  nc = nc + 1;
      endcase
      if (nr >= 0 && nc >= 0 && nr < side && nc < side) begin
        cidx = nr * MAX_SIDE + nc;
        if (!wall_bit[cidx] && !seen_bit[cidx]) begin
          found = 1'b1;
          seen_bit[cidx] = 1'b1;
          trail_row[trail_depth] = nr;
          trail_col[trail_depth] = nc;
          trail_next[trail_depth] = 0;
          trail_came[trail_depth] = kd;
          trail_depth++;
          queue_move(kd, 1'b0);
        end
      end
    end
    if (!found) begin
      if (trail_depth == 1) begin
        trail_depth = 0;
        walk_over = 1'b1;
        queue_move(DIR_UP, 1'b1);
      end else begin
        // Retreat by the opposite of the move that entered this cell.
        queue_move(trail_came[top] ^ 2'b01, 1'b0);
        trail_depth--;
      end
    end
  endtask

  task automatic apply_item(logic [1:0] cmd, logic [5:0] row, logic [5:0] col, logic blk);
    case (cmd)
      CMD_LOAD: wall_bit[{row, col}] = blk;
      CMD_RESTART: begin
        seen_bit = '{default: 1'b0};
        seen_bit[{start_row_cfg, start_col_cfg}] = 1'b1;
        trail_row[0] = start_row_cfg;
        trail_col[0] = start_col_cfg;
        trail_next[0] = 0;
        trail_came[0] = DIR_UP;
        trail_depth = 1;
        walk_over = 1'b0;
      end
      CMD_STEP: predict_move();
      default: ;
    endcase
  endtask

  task automatic send_beat(logic [1:0] cmd, logic [5:0] row, logic [5:0] col, logic blk);
    int gap;
    gap = ($urandom_range(99) < snd_idle_pct) ? $urandom_range(1, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {3'b000, blk, col, row};
    do @(posedge clk); while (!s_tready);
    apply_item(cmd, row, col, blk);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (moves_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [SIDE_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (addr)
      REG_GRID_SIDE: side_cfg = val;
      REG_START_ROW: start_row_cfg = val[COORD_W-1:0];
      REG_START_COL: start_col_cfg = val[COORD_W-1:0];
      default: ;
    endcase
  endtask

  // The top bit of a start write is random, since only six bits are kept.
  task automatic set_grid(int side, int sr, int sc);
    hold_until_drained();
    repeat (16) @(posedge clk);
    write_reg(REG_GRID_SIDE, side[SIDE_W-1:0]);
    write_reg(REG_START_ROW, {1'($urandom_range(1)), sr[5:0]});
    write_reg(REG_START_COL, {1'($urandom_range(1)), sc[5:0]});
  endtask

  // Loads a box of random walls and a ring of walls around it, so the walk
  // never looks at a cell that was not loaded.
  task automatic load_area(int r0, int c0, int h, int w, int dens);
    bit in_box;
    box_r0 = r0;
    box_c0 = c0;
    box_h = h;
    box_w = w;
    for (int r = r0 - 1; r <= r0 + h; r++) begin
      for (int c = c0 - 1; c <= c0 + w; c++) begin
        if (r < 0 || c < 0 || r >= MAX_SIDE || c >= MAX_SIDE) continue;
        in_box = (r >= r0 && r < r0 + h && c >= c0 && c < c0 + w);
        send_beat(CMD_LOAD, r[5:0], c[5:0], in_box ? ($urandom_range(99) < dens) : 1'b1);
      end
    end
  endtask

  task automatic walk_to_end(int noise_pct, int extra);
    int pick, r, c;
    bit in_box;
    while (!walk_over) begin
      if ($urandom_range(99) < noise_pct) begin
        pick = $urandom_range(99);
        if (box_h > 0 && $urandom_range(1)) begin
          r = box_r0 + $urandom_range(box_h - 1);
          c = box_c0 + $urandom_range(box_w - 1);
        end else begin
          r = $urandom_range(63);
          c = $urandom_range(63);
        end
        in_box = (r >= box_r0 && r < box_r0 + box_h && c >= box_c0 && c < box_c0 + box_w);
        if (pick < 60)
          send_beat(CMD_LOAD, r[5:0], c[5:0], in_box ? 1'($urandom_range(1)) : 1'b1);
        else if (pick < 95)
          send_beat(CMD_UNUSED, r[5:0], c[5:0], 1'($urandom_range(1)));
        else
          send_beat(CMD_RESTART, r[5:0], c[5:0], 1'($urandom_range(1)));
      end
      if ($urandom_range(99) < 2) hold_until_drained();
      send_beat(CMD_STEP, 6'($urandom_range(63)), 6'($urandom_range(63)),
                1'($urandom_range(1)));
    end
    repeat (extra)
      send_beat(CMD_STEP, 6'($urandom_range(63)), 6'($urandom_range(63)),
                1'($urandom_range(1)));
  endtask

  task automatic test_idle_steps();
    send_beat(CMD_STEP, 6'd63, 6'd63, 1'b1);
    send_beat(CMD_UNUSED, 6'd0, 6'd0, 1'b0);
  endtask

  task automatic test_zero_side();
    set_grid(0, 0, 0);
    box_h = 0;
    send_beat(CMD_RESTART, 6'd0, 6'd0, 1'b0);
    send_beat(CMD_STEP, 6'd0, 6'd0, 1'b0);
  endtask

  // A 2x2 tour moves in all four directions, forward or back; the start wall is ignored.
  task automatic test_small_grid();
    set_grid(2, 0, 0);
    box_h = 0;
    send_beat(CMD_LOAD, 6'd0, 6'd0, 1'b1);
    send_beat(CMD_LOAD, 6'd0, 6'd1, 1'b0);
    send_beat(CMD_LOAD, 6'd1, 6'd0, 1'b0);
    send_beat(CMD_LOAD, 6'd1, 6'd1, 1'b0);
    send_beat(CMD_RESTART, 6'd0, 6'd0, 1'b0);
    repeat (3) send_beat(CMD_STEP, 6'd0, 6'd0, 1'b0);
    hold_until_drained();
    walk_to_end(0, 1);
  endtask

  task automatic test_far_corner();
    set_grid(127, 63, 63);
    box_h = 0;
    send_beat(CMD_LOAD, 6'd63, 6'd63, 1'b1);
    send_beat(CMD_LOAD, 6'd63, 6'd62, 1'b0);
    send_beat(CMD_LOAD, 6'd62, 6'd62, 1'b1);
    send_beat(CMD_LOAD, 6'd62, 6'd63, 1'b1);
    send_beat(CMD_LOAD, 6'd63, 6'd61, 1'b1);
    send_beat(CMD_RESTART, 6'd0, 6'd0, 1'b0);
    walk_to_end(0, 0);
  endtask

  task automatic test_random_walks(int goal);
    int pick, side, eside, sr, sc, h, w, r0, c0;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 6) side = 0;
      else if (pick < 14) side = 1;
      else if (pick < 86) side = $urandom_range(2, 8);
      else side = $urandom_range(9, 127);
      eside = (side > MAX_SIDE) ? MAX_SIDE : side;
      sr = $urandom_range(63);
      sc = $urandom_range(63);
      if (eside > 0 && eside <= 8 && $urandom_range(99) < 12) begin
        // Start outside the grid: row, column or both beyond the side.
        pick = $urandom_range(2);
        if (pick != 1) sr = $urandom_range(eside, 63);
        else sr = $urandom_range(eside - 1);
        if (pick != 0) sc = $urandom_range(eside, 63);
        else sc = $urandom_range(eside - 1);
      end else if (eside > 0) begin
        sr = $urandom_range(eside - 1);
        sc = $urandom_range(eside - 1);
      end
      set_grid(side, sr, sc);
      if (eside == 0) begin
        box_h = 0;
      end else if (eside <= 8) begin
        load_area(0, 0, eside, eside, $urandom_range(40));
      end else begin
        h = $urandom_range(1, 6);
        w = $urandom_range(1, 6);
        r0 = sr - $urandom_range(h - 1);
        c0 = sc - $urandom_range(w - 1);
        if (r0 < 0) r0 = 0;
        if (c0 < 0) c0 = 0;
        if (r0 > MAX_SIDE - h) r0 = MAX_SIDE - h;
        if (c0 > MAX_SIDE - w) c0 = MAX_SIDE - w;
        load_area(r0, c0, h, w, $urandom_range(40));
      end
      send_beat(CMD_RESTART, 6'($urandom_range(63)), 6'($urandom_range(63)),
                1'($urandom_range(1)));
      walk_to_end(15, $urandom_range(2));
    end
  endtask

  always @(posedge clk) begin : check_moves
    move_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (moves_due.size() == 0) begin
        note_error($sformatf("beat with nothing expected: move_dir %0d tour_done %0d",
                             m_tdata[1:0], m_tuser[0]));
      end else begin
        want = moves_due.pop_front();
        if (m_tdata[1:0] !== want.dir || m_tuser[0] !== want.done)
          note_error($sformatf("move_dir exp %0d got %0d, tour_done exp %0d got %0d",
                               want.dir, m_tdata[1:0], want.done, m_tuser[0]));
      end
    end
  end

  initial begin
    snd_idle_pct = 38;
    rcv_idle_pct = 51;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_idle_steps();
    test_zero_side();
    test_small_grid();
    test_far_corner();
    test_random_walks(ITEM_GOAL / 3);
    snd_idle_pct = 51;
    rcv_idle_pct = 38;
    test_random_walks(2 * ITEM_GOAL / 3);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_walks(ITEM_GOAL);
    hold_until_drained();
    repeat (24) @(posedge clk);
    if (err_cnt == 0 && moves_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
